// ===== hw/rtl/e2d_pkg.sv =====
// Shared types, constants and calendar helpers for the epoch-to-date converter.
`timescale 1ns / 1ps

package e2d_pkg;

    localparam int SEC_BITS   = 31;
    localparam int YEAR_BITS  = 11;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int HOUR_BITS  = 5;
    localparam int MIN_BITS   = 6;
    localparam int OFF_BITS   = 4;
    // Whole days since the epoch fit in 15 bits for any 31-bit input plus offset.
    localparam int DAYS_BITS  = 15;

    localparam int SEC_RADIX  = 60;
    localparam int MIN_RADIX  = 60;
    localparam int HOUR_RADIX = 24;
    localparam int DAYS_RADIX = 1 << DAYS_BITS;

    localparam logic [YEAR_BITS-1:0]  BASE_YEAR     = 11'd1970;
    localparam logic [8:0]            DAYS_PER_YEAR = 9'd365;
    localparam logic [MONTH_BITS-1:0] LAST_MONTH    = 4'd11;
    localparam logic [MONTH_BITS-1:0] FEBRUARY      = 4'd1;

    typedef logic [YEAR_BITS-1:0]  t_year;
    typedef logic [MONTH_BITS-1:0] t_month;
    typedef logic [DAY_BITS-1:0]   t_day;
    typedef logic [HOUR_BITS-1:0]  t_hour;
    typedef logic [MIN_BITS-1:0]   t_minute;
    typedef logic [SEC_BITS-1:0]   t_secs;
    typedef logic [DAYS_BITS-1:0]  t_days;

    // Control shared by every cell of the digit chain.
    typedef struct packed {
        logic clr;
        logic en;
        logic dbl;
    } t_cell_ctl;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_day   day;
    } t_cal_res;

    // Length of a month, January as zero.
    function automatic logic [4:0] month_len(input t_month m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            FEBRUARY:                len = 5'd28 + {4'd0, leap};
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/e2d_if.sv =====
// Valid/ready channel interfaces for timestamps in and calendar dates out.
`timescale 1ns / 1ps

interface e2d_in_if import e2d_pkg::*; ();
    logic  valid;
    logic  ready;
    t_secs epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2d_out_if import e2d_pkg::*; ();
    logic    valid;
    logic    ready;
    t_year   year;
    t_month  month;
    t_day    day;
    t_hour   hour;
    t_minute minute;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, output ready);
endinterface

// ===== hw/rtl/e2d_cell.sv =====
// One mixed-radix digit of the time chain: double-and-carry or add-and-carry.
`timescale 1ns / 1ps

module e2d_cell import e2d_pkg::*; #(
    parameter int RADIX = 60,
    localparam int W    = $clog2(RADIX)
) (
    input  logic         i_clk,
    input  t_cell_ctl    i_ctl,
    input  logic [W-1:0] i_addend,
    input  logic         i_carry,
    output logic         o_carry,
    output logic [W-1:0] o_digit
);

    logic [W-1:0] r_digit;
    logic [W-1:0] n_digit;
    logic [W:0]   other;
    logic [W:0]   sum;

    // Digit stays below RADIX, so one subtract normalises 2*d+1 or d+offset.
    always_comb begin
        other   = i_ctl.dbl ? {1'b0, r_digit} : {1'b0, i_addend};
        sum     = {1'b0, r_digit} + other + {{W{1'b0}}, i_carry};
        o_carry = (sum >= (W+1)'(RADIX));
        n_digit = o_carry ? W'(sum - (W+1)'(RADIX)) : W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_digit <= '0;
        end else if (i_ctl.en) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// ===== hw/rtl/e2d_cal.sv =====
// Calendar walker: consumes whole days year by year, then month by month.
`timescale 1ns / 1ps

module e2d_cal import e2d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_days    i_days,
    input  logic     i_ack,
    output logic     o_done,
    output t_cal_res o_res
);

    localparam logic [1:0] C_IDLE  = 2'd0;
    localparam logic [1:0] C_YEAR  = 2'd1;
    localparam logic [1:0] C_MONTH = 2'd2;
    localparam logic [1:0] C_DONE  = 2'd3;

    logic [1:0] r_phase;
    t_days      r_days;
    t_year      r_year;
    t_month     r_month;
    logic       leap;
    t_days      year_len;
    t_days      mon_len;

    // Years stay below 2100, so every fourth year is a leap year here.
    always_comb begin
        leap     = (r_year[1:0] == 2'b00);
        year_len = DAYS_BITS'(DAYS_PER_YEAR) + {{(DAYS_BITS-1){1'b0}}, leap};
        mon_len  = DAYS_BITS'(month_len(r_month, leap && (r_month == FEBRUARY)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= C_IDLE;
        end else begin
            unique case (r_phase)
                C_IDLE: begin
                    if (i_start) begin
                        r_phase <= C_YEAR;
                    end
                end
                C_YEAR: begin
                    if (r_days < year_len) begin
                        r_phase <= C_MONTH;
                    end
                end
                C_MONTH: begin
                    if (r_month == LAST_MONTH || r_days < mon_len) begin
                        r_phase <= C_DONE;
                    end
                end
                C_DONE: begin
                    if (i_ack) begin
                        r_phase <= C_IDLE;
                    end
                end
                default: r_phase <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == C_IDLE && i_start) begin
            r_days  <= i_days;
            r_year  <= BASE_YEAR;
            r_month <= '0;
        end else if (r_phase == C_YEAR && r_days >= year_len) begin
            r_days <= r_days - year_len;
            r_year <= r_year + 1'b1;
        end else if (r_phase == C_MONTH && r_month != LAST_MONTH && r_days >= mon_len) begin
            r_days  <= r_days - mon_len;
            r_month <= r_month + 1'b1;
        end
    end

    assign o_done      = (r_phase == C_DONE);
    assign o_res.year  = r_year;
    assign o_res.month = r_month + 1'b1;
    assign o_res.day   = DAY_BITS'(r_days) + 1'b1;

endmodule

// ===== hw/rtl/epoch_seconds_to_date_unit.sv =====
// Top level: Unix seconds to year, month, day, hour and minute, with hour offset.
`timescale 1ns / 1ps

// Converts a 31-bit count of seconds since 1970-01-01 00:00 into a Gregorian date
// and time of day, after adding utc_offset_hours (register 0, byte address 0,
// reset value 1; only the low 4 bits are kept). Seconds are dropped. One
// timestamp is handled at a time: the input is shifted MSB first through a row
// of four digit cells (seconds, minutes, hours, days), the offset is then added
// to the hours cell, and the calendar walker steps year by year from 1970 and
// then month by month. The finished result waits in an output register, and
// the next timestamp is accepted meanwhile.
module epoch_seconds_to_date_unit import e2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    e2d_in_if.sink      i_in,
    e2d_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_OFFS   = 3'd2;
    localparam logic [2:0] S_LAUNCH = 3'd3;
    localparam logic [2:0] S_CAL    = 3'd4;

    localparam logic REG_UTC_OFFSET = 1'b0;
    localparam int   CNT_BITS       = $clog2(SEC_BITS);

    logic [2:0]          r_state;
    logic [CNT_BITS-1:0] r_cnt;
    t_secs               r_secs;
    logic [OFF_BITS-1:0] r_utc_offset;
    logic                r_out_valid;
    t_year               r_year;
    t_month              r_month;
    t_day                r_day;
    t_hour               r_hour;
    t_minute             r_minute;

    t_cell_ctl cell_ctl;
    logic      in_fire;
    logic      cfg_wr;
    logic      sec_carry;
    logic      min_carry;
    logic      hour_carry;
    t_minute   min_digit;
    t_hour     hour_digit;
    t_hour     hour_addend;
    t_days     days_digit;
    logic      cal_done;
    logic      cal_ack;
    t_cal_res  cal_res;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_UTC_OFFSET);
    assign prdata = (paddr[2] == REG_UTC_OFFSET) ? {{(32-OFF_BITS){1'b0}}, r_utc_offset}
                                                 : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utc_offset <= OFF_BITS'(1);
        end else if (cfg_wr) begin
            r_utc_offset <= pwdata[OFF_BITS-1:0];
        end
    end

    // Digit chain control: clear on accept, double during the shift, add offset once.
    always_comb begin
        cell_ctl.clr = in_fire;
        cell_ctl.en  = (r_state == S_CONV) || (r_state == S_OFFS);
        cell_ctl.dbl = (r_state == S_CONV);
        hour_addend  = (r_state == S_OFFS) ? HOUR_BITS'(r_utc_offset) : '0;
    end

    e2d_cell #(.RADIX(SEC_RADIX)) u_sec_cell (
        .i_clk    (i_clk),
        .i_ctl    (cell_ctl),
        .i_addend ('0),
        .i_carry  (cell_ctl.dbl && r_secs[SEC_BITS-1]),
        .o_carry  (sec_carry),
        .o_digit  ()
    );

    e2d_cell #(.RADIX(MIN_RADIX)) u_min_cell (
        .i_clk    (i_clk),
        .i_ctl    (cell_ctl),
        .i_addend ('0),
        .i_carry  (sec_carry),
        .o_carry  (min_carry),
        .o_digit  (min_digit)
    );

    e2d_cell #(.RADIX(HOUR_RADIX)) u_hour_cell (
        .i_clk    (i_clk),
        .i_ctl    (cell_ctl),
        .i_addend (hour_addend),
        .i_carry  (min_carry),
        .o_carry  (hour_carry),
        .o_digit  (hour_digit)
    );

    e2d_cell #(.RADIX(DAYS_RADIX)) u_day_cell (
        .i_clk    (i_clk),
        .i_ctl    (cell_ctl),
        .i_addend ('0),
        .i_carry  (hour_carry),
        .o_carry  (),
        .o_digit  (days_digit)
    );

    e2d_cal u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LAUNCH),
        .i_days  (days_digit),
        .i_ack   (cal_ack),
        .o_done  (cal_done),
        .o_res   (cal_res)
    );

    // Hand the result over only when the output register is free or draining.
    assign cal_ack = (r_state == S_CAL) && cal_done && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_cnt == CNT_BITS'(SEC_BITS - 1)) begin
                        r_state <= S_OFFS;
                    end
                end
                S_OFFS:   r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_CAL;
                S_CAL: begin
                    if (cal_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Shift the timestamp out MSB first
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_secs <= i_in.epoch_seconds;
            r_cnt  <= '0;
        end else if (r_state == S_CONV) begin
            r_secs <= {r_secs[SEC_BITS-2:0], 1'b0};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cal_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cal_ack) begin
            r_year   <= cal_res.year;
            r_month  <= cal_res.month;
            r_day    <= cal_res.day;
            r_hour   <= hour_digit;
            r_minute <= min_digit;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.year   = r_year;
    assign o_out.month  = r_month;
    assign o_out.day    = r_day;
    assign o_out.hour   = r_hour;
    assign o_out.minute = r_minute;

endmodule
